// File: rtl/core/gls_pkg.sv
package gls_pkg;

  localparam int GRID_WIDTH_DEF  = 64;
  localparam int GRID_HEIGHT_DEF = 64;
  localparam int COORD_W         = 6;
  localparam int DIST_W          = 8;
  localparam int ERR_W           = COORD_W + 3;

  // Item kinds on the mode field
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef logic [COORD_W-1:0]      coord_t;
  typedef logic [DIST_W-1:0]       dist_t;
  typedef logic signed [ERR_W-1:0] err_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_DONE
  } state_t;

  // Current walker position and line constants
  typedef struct packed {
    coord_t x;
    coord_t y;
    err_t   err;
    coord_t dx;
    coord_t dy;
    logic   sx_neg;
    logic   sy_neg;
  } step_in_t;

  // Position and error term after one step
  typedef struct packed {
    coord_t x;
    coord_t y;
    err_t   err;
  } step_out_t;

endpackage

// File: rtl/core/grid_line_of_sight_unit.sv
// Line-of-sight unit over a one-bit blocking map of GRID_WIDTH x GRID_HEIGHT tiles.
// Input channel (in_valid/in_ready): mode 0 writes one map cell (cell_x, cell_y,
// cell_blocked) and gives no result; mode 1 asks a query from start to end tile
// with a Chebyshev limit max_dist. Output channel (out_valid/out_ready) carries
// one result per query: visible and out_of_range.
// Reset starts a clearing pass that writes every map cell open, one cell per
// cycle; in_ready stays low until it ends.
// A write goes into the map at its transfer; the next item may follow in the
// next cycle.
// A query goes from IDLE through WALK to DONE, where its result is loaded; in
// WALK it takes the Bresenham steps actually walked (at most the Chebyshev
// distance, 63). The walker steps one cell per cycle: the map RAM
// has one registered read port, so the blocker check of a cell overlaps the
// step to the next one. An out-of-range or zero-length query skips WALK.
// One item is in work at a time; in_ready is high only while the unit idles,
// so the next item after a query can transfer once the unit is back in idle.
// The result sits in an output register: a stalled receiver does not stop the
// unit from taking the next item, but a finished query holds until that
// register is free.
module grid_line_of_sight_unit #(
  parameter int GRID_WIDTH  = gls_pkg::GRID_WIDTH_DEF,
  parameter int GRID_HEIGHT = gls_pkg::GRID_HEIGHT_DEF
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  logic                   mode,
  input  gls_pkg::coord_t        cell_x,
  input  gls_pkg::coord_t        cell_y,
  input  logic                   cell_blocked,
  input  gls_pkg::coord_t        start_x,
  input  gls_pkg::coord_t        start_y,
  input  gls_pkg::coord_t        end_x,
  input  gls_pkg::coord_t        end_y,
  input  gls_pkg::dist_t         max_dist,
  output logic                   out_valid,
  input  logic                   out_ready,
  output logic                   visible,
  output logic                   out_of_range
);
  import gls_pkg::*;

  localparam int CELLS = GRID_WIDTH * GRID_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam logic [AW-1:0] LAST_ADDR = AW'(CELLS - 1);

  state_t state;
  state_t state_next;

  // walker registers
  logic [AW-1:0] clr_addr;
  coord_t        x;
  coord_t        y;
  coord_t        x1;
  coord_t        y1;
  coord_t        dx;
  coord_t        dy;
  logic          sx_neg;
  logic          sy_neg;
  err_t          err;
  coord_t        remaining;
  logic          chk_pend;
  logic          chk_end;
  logic          chk_oob;
  logic          res_vis;
  logic          res_oor;

  // query setup
  coord_t adx;
  coord_t ady;
  coord_t steps;
  logic   too_far;
  logic   take_query;
  logic   take_write;
  logic   cell_in_grid;

  // walk datapath
  step_in_t   step_cur;
  step_out_t  step_nxt;
  logic       nxt_in_grid;
  logic       blocked_now;
  logic       walk_done;
  logic       step_en;
  logic       load_out;
  logic [31:0] cell_addr_w;
  logic [31:0] step_addr_w;

  // map RAM
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic          ram_wdata;
  logic [0:0]    ram_rdata;

  assign take_query = in_valid && in_ready && (mode == MODE_QUERY);
  assign take_write = in_valid && in_ready && (mode == MODE_WRITE);

  // Chebyshev distance of the query endpoints
  assign adx     = (start_x > end_x) ? start_x - end_x : end_x - start_x;
  assign ady     = (start_y > end_y) ? start_y - end_y : end_y - start_y;
  assign steps   = (adx > ady) ? adx : ady;
  assign too_far = {{(DIST_W-COORD_W){1'b0}}, steps} > max_dist;

  assign cell_in_grid = (32'(cell_x) < 32'(GRID_WIDTH)) && (32'(cell_y) < 32'(GRID_HEIGHT));
  assign cell_addr_w  = 32'(cell_y) * 32'(GRID_WIDTH) + 32'(cell_x);

  assign step_cur = '{x: x, y: y, err: err, dx: dx, dy: dy, sx_neg: sx_neg, sy_neg: sy_neg};

  gls_step u_step (
    .cur (step_cur),
    .nxt (step_nxt)
  );

  assign nxt_in_grid = (32'(step_nxt.x) < 32'(GRID_WIDTH)) &&
                       (32'(step_nxt.y) < 32'(GRID_HEIGHT));
  assign step_addr_w = 32'(step_nxt.y) * 32'(GRID_WIDTH) + 32'(step_nxt.x);

  // The cell read last cycle is checked now; the end tile never blocks,
  // a cell off the grid always does.
  assign blocked_now = chk_pend && !chk_end && (chk_oob || ram_rdata[0]);
  assign walk_done   = blocked_now || (remaining == '0);

  gls_ram #(
    .WIDTH (1),
    .DEPTH (CELLS)
  ) u_map (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (step_addr_w[AW-1:0]),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == LAST_ADDR) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take_query) begin
          state_next = (too_far || steps == '0) ? ST_DONE : ST_WALK;
        end
      end
      ST_WALK: begin
        if (walk_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready  = 1'b0;
    ram_we    = 1'b0;
    ram_waddr = cell_addr_w[AW-1:0];
    ram_wdata = cell_blocked;
    step_en   = 1'b0;
    load_out  = 1'b0;
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_addr;
        ram_wdata = 1'b0;
      end
      ST_IDLE: begin
        in_ready = 1'b1;
        ram_we   = take_write && cell_in_grid;
      end
      ST_WALK: begin
        step_en = !walk_done;
      end
      ST_DONE: begin
        load_out = !out_valid || out_ready;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      chk_pend  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;

      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + AW'(1);
      end

      // Latch the line and decide the range check at once
      if (take_query) begin
        x         <= start_x;
        y         <= start_y;
        x1        <= end_x;
        y1        <= end_y;
        dx        <= adx;
        dy        <= ady;
        sx_neg    <= !(start_x < end_x);
        sy_neg    <= !(start_y < end_y);
        err       <= $signed({3'b000, adx}) - $signed({3'b000, ady});
        remaining <= steps;
        chk_pend  <= 1'b0;
        res_vis   <= !too_far;
        res_oor   <= too_far;
      end

      // Advance one cell and issue its map read
      if (step_en) begin
        x         <= step_nxt.x;
        y         <= step_nxt.y;
        err       <= step_nxt.err;
        remaining <= remaining - coord_t'(1);
        chk_pend  <= 1'b1;
        chk_end   <= (step_nxt.x == x1) && (step_nxt.y == y1);
        chk_oob   <= !nxt_in_grid;
      end

      if (state == ST_WALK && walk_done) begin
        res_vis  <= !blocked_now;
        res_oor  <= 1'b0;
        chk_pend <= 1'b0;
      end

      // Output register: load a finished result, drop it once transferred
      if (load_out) begin
        out_valid    <= 1'b1;
        visible      <= res_vis;
        out_of_range <= res_oor;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/gls_ram.sv
module gls_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/gls_step.sv
module gls_step (
  input  gls_pkg::step_in_t  cur,
  output gls_pkg::step_out_t nxt
);
  import gls_pkg::*;

  logic signed [ERR_W:0] e2;
  logic signed [ERR_W:0] dx_s;
  logic signed [ERR_W:0] dy_s;
  logic signed [ERR_W:0] err_w;
  logic signed [ERR_W:0] err_sum;
  logic                  step_x;
  logic                  step_y;

  assign dx_s  = $signed({4'b0000, cur.dx});
  assign dy_s  = $signed({4'b0000, cur.dy});
  assign err_w = $signed({cur.err[ERR_W-1], cur.err});
  assign e2    = $signed({cur.err, 1'b0});

  // Bresenham decision: advance x, y or both
  assign step_x = e2 > -dy_s;
  assign step_y = e2 < dx_s;

  assign err_sum = err_w - (step_x ? dy_s : '0) + (step_y ? dx_s : '0);

  always_comb begin
    nxt.err = $signed(err_sum[ERR_W-1:0]);
    nxt.x   = cur.x;
    nxt.y   = cur.y;
    if (step_x) begin
      nxt.x = cur.sx_neg ? cur.x - coord_t'(1) : cur.x + coord_t'(1);
    end
    if (step_y) begin
      nxt.y = cur.sy_neg ? cur.y - coord_t'(1) : cur.y + coord_t'(1);
    end
  end

endmodule
